// File: rtl/core/sdos_pkg.sv
// ----------------------------------------------------------------------------
// sdos_pkg
// Shared types and the ordering function for the stable depth-order sorter.
// ----------------------------------------------------------------------------
package sdos_pkg;

    localparam int DEPTH_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int HANDLE_W = 16;

    typedef struct packed {
        logic signed [DEPTH_W-1:0]  depth;
        logic        [STAMP_W-1:0]  stamp;
        logic        [HANDLE_W-1:0] handle;
    } t_entry;

    // Neighbor view of one cell: its content, whether it holds an entry, and
    // whether the incoming entry sorts strictly before it.
    typedef struct packed {
        t_entry entry;
        logic   valid;
        logic   less;
    } t_link;

    // Per-cycle chain commands.
    typedef struct packed {
        logic insert;  // place the incoming entry this cycle
        logic shift;   // advance every cell one step toward cell 0
    } t_cell_ctl;

    // True when a sorts strictly before b: depth first, then stamp.
    function automatic logic key_less(input t_entry a, input t_entry b);
        logic [DEPTH_W+STAMP_W-1:0] ka;
        logic [DEPTH_W+STAMP_W-1:0] kb;
        ka = {~a.depth[DEPTH_W-1], a.depth[DEPTH_W-2:0], a.stamp};
        kb = {~b.depth[DEPTH_W-1], b.depth[DEPTH_W-2:0], b.stamp};
        return ka < kb;
    endfunction

endpackage

// File: rtl/core/sdos_cell.sv
// ----------------------------------------------------------------------------
// sdos_cell
// One slot of the insertion chain: holds an entry, takes the incoming entry,
// its lower neighbor's entry, or its upper neighbor's entry on drain.
// ----------------------------------------------------------------------------
module sdos_cell
    import sdos_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_link     i_prev,
    input  t_link     i_next,
    output t_link     o_link
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;
    logic   less;
    logic   take_prev;
    logic   take_new;

    assign less = r_valid && key_less(i_new, r_entry);

    // Shift up from below when the new entry lands under us; land it here when
    // this is the first slot it sorts before (or the first free slot).
    assign take_prev = i_ctl.insert && i_prev.less;
    assign take_new  = i_ctl.insert && !i_prev.less && i_prev.valid && (less || !r_valid);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_entry = i_next.entry;
            n_valid = i_next.valid;
        end else if (take_prev) begin
            n_entry = i_prev.entry;
            n_valid = 1'b1;
        end else if (take_new) begin
            n_entry = i_new;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.entry = r_entry;
    assign o_link.valid = r_valid;
    assign o_link.less  = less;

endmodule

// File: rtl/core/stable_depth_order_sorter.sv
// ----------------------------------------------------------------------------
// stable_depth_order_sorter
// Collects a set of entries into a sorted chain of cells and drains it in
// ascending depth/stamp order when the beat marked last arrives.
// ----------------------------------------------------------------------------
// Load: one input beat per cycle; each entry is placed in its sorted slot in
//   the same cycle it is accepted (one compare per cell against the new key).
// Drain: first result in the cycle after the last beat, then one result per
//   cycle while not stalled; a set takes one output beat per stored entry (at
//   most MAX_ENTRIES), during which the input side is stalled.
// Reset: clears the cell valid bits, the drain flag and the overflow flag.
// ----------------------------------------------------------------------------
module stable_depth_order_sorter
    import sdos_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [DEPTH_W-1:0]  i_depth_order,
    input  logic        [STAMP_W-1:0]  i_arrival_stamp,
    input  logic        [HANDLE_W-1:0] i_entry_handle,
    input  logic                       i_last_entry,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [DEPTH_W-1:0]  o_sorted_depth,
    output logic        [STAMP_W-1:0]  o_sorted_stamp,
    output logic        [HANDLE_W-1:0] o_sorted_handle,
    output logic                       o_end_of_run,
    output logic                       o_overflowed
);

    t_entry                 new_entry;
    t_cell_ctl              ctl;
    t_link                  links [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_valid;

    logic r_draining;
    logic n_draining;
    logic r_overflow;
    logic n_overflow;
    logic in_beat;
    logic out_beat;
    logic full;

    assign new_entry.depth  = i_depth_order;
    assign new_entry.stamp  = i_arrival_stamp;
    assign new_entry.handle = i_entry_handle;

    // Input is held off for the whole drain; the chain is the output register.
    assign o_stall  = r_draining;
    assign in_beat  = i_valid && !r_draining;
    assign out_beat = o_valid && !i_stall;
    assign full     = cell_valid[MAX_ENTRIES-1];

    // Drop the entry when the chain is full; the set still closes on last.
    assign ctl.insert = in_beat && !full;
    assign ctl.shift  = out_beat;

    // ---- cell chain --------------------------------------------------------
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_link prev_link;
        t_link next_link;

        if (g == 0) begin : g_head
            // Cell 0 sees a filled, never-smaller neighbor below it.
            assign prev_link.entry = '0;
            assign prev_link.valid = 1'b1;
            assign prev_link.less  = 1'b0;
        end else begin : g_body
            assign prev_link = links[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            // Empty slot shifts in at the top on drain.
            assign next_link.entry = '0;
            assign next_link.valid = 1'b0;
            assign next_link.less  = 1'b0;
        end else begin : g_mid
            assign next_link = links[g+1];
        end

        sdos_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_new   (new_entry),
            .i_prev  (prev_link),
            .i_next  (next_link),
            .o_link  (links[g])
        );

        assign cell_valid[g] = links[g].valid;
    end

    // ---- set control -------------------------------------------------------
    always_comb begin
        n_draining = r_draining;
        n_overflow = r_overflow;
        if (r_draining) begin
            // Close the set once the final entry leaves cell 0.
            if (out_beat && o_end_of_run) begin
                n_draining = 1'b0;
                n_overflow = 1'b0;
            end
        end else if (in_beat) begin
            if (full) begin
                n_overflow = 1'b1;
            end
            if (i_last_entry) begin
                n_draining = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_overflow <= n_overflow;
        end
    end

    // ---- result channel ----------------------------------------------------
    assign o_valid         = r_draining && cell_valid[0];
    assign o_sorted_depth  = links[0].entry.depth;
    assign o_sorted_stamp  = links[0].entry.stamp;
    assign o_sorted_handle = links[0].entry.handle;
    assign o_end_of_run    = !cell_valid[1];
    assign o_overflowed    = r_overflow;

    // ---- assertions --------------------------------------------------------
    // Filled cells always form a contiguous run starting at cell 0.
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("cell valid bits not contiguous");

    // The two lowest cells stay in sorted order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[1] |-> !key_less(links[1].entry, links[0].entry))
        else $error("chain head out of order");

    // An accepted entry that is not dropped leaves cell 0 filled.
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.insert |=> cell_valid[0])
        else $error("insert left chain empty");

    // After the final result beat the drain is over and the chain is empty.
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_end_of_run) |=> (!o_valid && !o_stall && !cell_valid[0]))
        else $error("drain did not close the set");

endmodule
